/* hdl/heightmap_vertex_normal_gen_unit_defines.svh */
// ----------------------------------------------------------------------------
// Height map vertex unit assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_GEN_UNIT_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMAL_GEN_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define HVN_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define HVN_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/hvn_pkg.sv */
// ----------------------------------------------------------------------------
// Height map vertex unit package
// Shared types, constants and the height conversion function.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int IDX_W    = 12;
  localparam int DIM_W    = 11;
  localparam int SIZE_W   = 16;
  localparam int SAMPLE_W = 8;
  localparam int HQ_W     = 15;
  localparam int NORM_ONE = 16384;
  localparam int DIV_NW   = 46;
  localparam int DIV_DW   = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int HQ_SCALE = 20480;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_SIZE_X,
    CFG_SIZE_Z
  } cfg_index_t;

  // One vertex to be computed by the back end.
  typedef struct packed {
    logic [IDX_W-1:0]    col;
    logic [IDX_W-1:0]    row;
    logic [SAMPLE_W-1:0] sl;
    logic [SAMPLE_W-1:0] sc;
    logic [SAMPLE_W-1:0] sr;
    logic [SAMPLE_W-1:0] sd;
    logic [SAMPLE_W-1:0] su;
    logic                last;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  // floor(s*20480/255): reciprocal multiply by 257/65536 with one correction step.
  function automatic logic [HQ_W-1:0] height_q(input logic [SAMPLE_W-1:0] s);
    logic [22:0] x;
    logic [31:0] t;
    logic [HQ_W-1:0] q;
    logic [22:0] rem;
    x = 23'(s) * 23'(HQ_SCALE);
    t = 32'(x) * 32'd257;
    q = t[30:16];
    rem = x - 23'(q) * 23'd255;
    if (rem >= 23'd255) begin
      q = q + 15'd1;
    end
    return q;
  endfunction

endpackage

/* hdl/hvn_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hvn_front.sv */
// ----------------------------------------------------------------------------
// Height map vertex front end
// Accepts samples, keeps the line store and emits vertex jobs.
// ----------------------------------------------------------------------------
module hvn_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_clear,
  input  logic [hvn_pkg::DIM_W-1:0]    w_eff,
  input  logic [hvn_pkg::DIM_W-1:0]    h_eff,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hvn_pkg::SAMPLE_W-1:0] height_sample,
  output logic                         job_valid,
  input  logic                         job_full,
  output hvn_pkg::job_t                job_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {F_IDLE, F_READ, F_PUSH} fstate_t;

  fstate_t state;
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [1:0]    slot;
  logic [7:0]    left_hold, center_hold;
  logic [CW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic [1:0]    slot_q;
  logic [7:0]    s_q, lh_q, ch_q;
  logic [7:0]    sc_rd, sl_rd, sr_rd, sd_rd;
  logic [2:0]    rd_k;
  logic [1:0]    jsel;

  logic          accept;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  logic [CW-1:0] cl_q, cr_q;
  logic [1:0]    pr_slot, dn_slot;
  logic          last_row, j1_ok, j2_ok;

  function automatic logic [AW-1:0] st_addr(input logic [1:0] slot_sel,
                                            input logic [CW-1:0] col_sel);
    return AW'(slot_sel) * AW'(MAX_WIDTH) + AW'(col_sel);
  endfunction

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign waddr    = st_addr(slot, col_cnt);

  hvn_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata(height_sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    cl_q = (c_q != '0) ? c_q - CW'(1) : c_q;
    cr_q = ((13'(c_q) + 13'd1) < 13'(w_eff)) ? c_q + CW'(1) : c_q;
    pr_slot = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;
    if (r_q == RW'(1)) begin
      dn_slot = pr_slot;
    end else begin
      dn_slot = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
    end
    last_row = (13'(r_q) + 13'd1) == 13'(h_eff);
    j1_ok = last_row && (c_q != '0);
    j2_ok = last_row && ((13'(c_q) + 13'd1) == 13'(w_eff));
  end

  always_comb begin
    unique case (rd_k)
      3'd1:    raddr = st_addr(pr_slot, cl_q);
      3'd2:    raddr = st_addr(pr_slot, cr_q);
      3'd3:    raddr = st_addr(dn_slot, c_q);
      default: raddr = st_addr(pr_slot, c_q);
    endcase
  end

  always_comb begin
    job_valid = (state == F_PUSH);
    unique case (jsel)
      2'd1: begin
        job_data.col  = hvn_pkg::IDX_W'(cl_q);
        job_data.row  = hvn_pkg::IDX_W'(r_q);
        job_data.sl   = (c_q >= CW'(2)) ? lh_q : ch_q;
        job_data.sc   = ch_q;
        job_data.sr   = s_q;
        job_data.sd   = sl_rd;
        job_data.su   = ch_q;
        job_data.last = 1'b0;
      end
      2'd2: begin
        job_data.col  = hvn_pkg::IDX_W'(c_q);
        job_data.row  = hvn_pkg::IDX_W'(r_q);
        job_data.sl   = ch_q;
        job_data.sc   = s_q;
        job_data.sr   = s_q;
        job_data.sd   = sc_rd;
        job_data.su   = s_q;
        job_data.last = 1'b1;
      end
      default: begin
        job_data.col  = hvn_pkg::IDX_W'(c_q);
        job_data.row  = hvn_pkg::IDX_W'(r_q - RW'(1));
        job_data.sl   = sl_rd;
        job_data.sc   = sc_rd;
        job_data.sr   = sr_rd;
        job_data.sd   = sd_rd;
        job_data.su   = s_q;
        job_data.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      col_cnt     <= '0;
      row_cnt     <= '0;
      slot        <= 2'd0;
      left_hold   <= '0;
      center_hold <= '0;
      rd_k        <= '0;
      jsel        <= '0;
    end else if (cfg_clear) begin
      col_cnt     <= '0;
      row_cnt     <= '0;
      slot        <= 2'd0;
      left_hold   <= '0;
      center_hold <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            c_q         <= col_cnt;
            r_q         <= row_cnt;
            slot_q      <= slot;
            s_q         <= height_sample;
            lh_q        <= left_hold;
            ch_q        <= center_hold;
            left_hold   <= center_hold;
            center_hold <= height_sample;
            rd_k        <= '0;
            jsel        <= '0;
            if ((13'(col_cnt) + 13'd1) >= 13'(w_eff)) begin
              col_cnt <= '0;
              if ((13'(row_cnt) + 13'd1) >= 13'(h_eff)) begin
                row_cnt <= '0;
                slot    <= 2'd0;
              end else begin
                row_cnt <= row_cnt + RW'(1);
                slot    <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
              end
            end else begin
              col_cnt <= col_cnt + CW'(1);
            end
            // The first row only fills the store.
            if (row_cnt != '0) begin
              state <= F_READ;
            end
          end
        end
        F_READ: begin
          unique case (rd_k)
            3'd1:    sc_rd <= rdata;
            3'd2:    sl_rd <= rdata;
            3'd3:    sr_rd <= rdata;
            3'd4:    sd_rd <= rdata;
            default: ;
          endcase
          if (rd_k == 3'd4) begin
            state <= F_PUSH;
          end else begin
            rd_k <= rd_k + 3'd1;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            if (jsel == 2'd0 && j1_ok) begin
              jsel <= 2'd1;
            end else if (jsel != 2'd2 && j2_ok) begin
              jsel <= 2'd2;
            end else begin
              state <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hdl/hvn_queue.sv */
// ----------------------------------------------------------------------------
// Height map vertex job queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module hvn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hvn_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output hvn_pkg::job_t pop_data,
  output logic          empty
);

  localparam int PW = $clog2(hvn_pkg::QUEUE_DEPTH);

  hvn_pkg::job_t slots [hvn_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full     = (count == (PW+1)'(hvn_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

/* hdl/hvn_div.sv */
// ----------------------------------------------------------------------------
// Height map vertex divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hvn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  hvn_pkg::div_req_t          req,
  output logic                       done,
  output logic [hvn_pkg::DIV_NW-1:0] quotient
);

  localparam int NW = hvn_pkg::DIV_NW;
  localparam int DW = hvn_pkg::DIV_DW;
  localparam int KW = $clog2(NW);

  logic [DW-1:0] rem, dsr;
  logic [KW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[NW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      quotient <= req.dividend;
      dsr      <= req.divisor;
      rem      <= '0;
      cnt      <= KW'(NW - 1);
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      rem      <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - KW'(1);
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

/* hdl/hvn_back.sv */
// ----------------------------------------------------------------------------
// Height map vertex back end
// Computes position, height and unit normal of one vertex job at a time.
// ----------------------------------------------------------------------------
module hvn_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hvn_pkg::DIM_W-1:0]     w_eff,
  input  logic [hvn_pkg::DIM_W-1:0]     h_eff,
  input  logic [hvn_pkg::SIZE_W-1:0]    size_x,
  input  logic [hvn_pkg::SIZE_W-1:0]    size_z,
  input  logic                          job_empty,
  input  hvn_pkg::job_t                 job_data,
  output logic                          job_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   pos_x,
  output logic [14:0]                   pos_height,
  output logic [15:0]                   pos_z,
  output logic signed [15:0]            normal_x,
  output logic [14:0]                   normal_y,
  output logic signed [15:0]            normal_z,
  output logic [9:0]                    tex_u,
  output logic [9:0]                    tex_v,
  output logic                          frame_last
);

  localparam int IW = hvn_pkg::IDX_W;

  typedef enum logic [3:0] {
    B_IDLE, B_PREP, B_PMUL, B_PDIV, B_PWAIT, B_AMUL, B_ASTORE, B_NORM,
    B_SQMUL, B_SQACC, B_SQRT, B_SDIV, B_SWAIT, B_FIN, B_OUT
  } bstate_t;

  bstate_t state;
  hvn_pkg::job_t job_q;
  logic [14:0] h_c, dhx_mag, dhz_mag;
  logic        dhx_pos, dhz_pos;
  logic [IW-1:0] idx [6];
  logic [15:0] pq [6];
  logic [2:0]  pk;
  logic [1:0]  ck;
  logic [39:0] comp [3];
  logic [14:0] nm [3];
  logic [61:0] sum;
  logic [62:0] sq_v, sq_res, sq_bit;
  logic [4:0]  sq_cnt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  hvn_pkg::div_req_t div_req;
  logic        div_done;
  logic [hvn_pkg::DIV_NW-1:0] div_quo;

  logic [15:0] dx, dz;
  logic [39:0] m01, m_max;
  logic [62:0] sq_trial;
  logic [14:0] hq_l, hq_r, hq_d, hq_u, hq_c;
  logic [15:0] dhx_s, dhz_s;

  assign job_pop = (state == B_IDLE) && !job_empty;
  assign dx = pq[2] - pq[1];
  assign dz = pq[5] - pq[4];
  assign m01 = (comp[0] > comp[1]) ? comp[0] : comp[1];
  assign m_max = (comp[2] > m01) ? comp[2] : m01;
  assign sq_trial = sq_res + sq_bit;

  assign hq_l = hvn_pkg::height_q(job_q.sl);
  assign hq_r = hvn_pkg::height_q(job_q.sr);
  assign hq_d = hvn_pkg::height_q(job_q.sd);
  assign hq_u = hvn_pkg::height_q(job_q.su);
  assign hq_c = hvn_pkg::height_q(job_q.sc);
  assign dhx_s = {1'b0, hq_r} - {1'b0, hq_l};
  assign dhz_s = {1'b0, hq_u} - {1'b0, hq_d};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      B_PMUL: begin
        mul_a = 32'(idx[pk]);
        mul_b = (pk < 3'd3) ? 32'(size_x) : 32'(size_z);
      end
      B_AMUL: begin
        unique case (ck)
          2'd0:    begin mul_a = 32'(dz); mul_b = 32'(dhx_mag); end
          2'd1:    begin mul_a = 32'(dz); mul_b = 32'(dx); end
          default: begin mul_a = 32'(dx); mul_b = 32'(dhz_mag); end
        endcase
      end
      B_SQMUL: begin
        mul_a = 32'(comp[ck][29:0]);
        mul_b = 32'(comp[ck][29:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_comb begin
    div_req.start    = (state == B_PDIV) || (state == B_SDIV);
    if (state == B_SDIV) begin
      div_req.dividend = hvn_pkg::DIV_NW'({comp[ck][29:0], 15'd0})
                       + hvn_pkg::DIV_NW'(sq_res[30:0]);
      div_req.divisor  = {sq_res[30:0], 1'b0};
    end else begin
      div_req.dividend = hvn_pkg::DIV_NW'(mul_p[27:0]);
      div_req.divisor  = (pk < 3'd3) ? 32'(w_eff) : 32'(h_eff);
    end
  end

  hvn_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      pk        <= '0;
      ck        <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!job_empty) begin
            job_q <= job_data;
            state <= B_PREP;
          end
        end
        B_PREP: begin
          h_c     <= hq_c;
          dhx_pos <= !dhx_s[15] && (dhx_s != '0);
          dhz_pos <= !dhz_s[15] && (dhz_s != '0);
          dhx_mag <= dhx_s[15] ? 15'(16'd0 - dhx_s) : dhx_s[14:0];
          dhz_mag <= dhz_s[15] ? 15'(16'd0 - dhz_s) : dhz_s[14:0];
          idx[0]  <= job_q.col;
          idx[1]  <= (job_q.col != '0) ? job_q.col - IW'(1) : job_q.col;
          idx[2]  <= ((13'(job_q.col) + 13'd1) < 13'(w_eff)) ?
                     job_q.col + IW'(1) : job_q.col;
          idx[3]  <= job_q.row;
          idx[4]  <= (job_q.row != '0) ? job_q.row - IW'(1) : job_q.row;
          idx[5]  <= ((13'(job_q.row) + 13'd1) < 13'(h_eff)) ?
                     job_q.row + IW'(1) : job_q.row;
          pk      <= '0;
          state   <= B_PMUL;
        end
        B_PMUL: state <= B_PDIV;
        B_PDIV: state <= B_PWAIT;
        B_PWAIT: begin
          if (div_done) begin
            pq[pk] <= div_quo[15:0];
            if (pk == 3'd5) begin
              ck    <= '0;
              state <= B_AMUL;
            end else begin
              pk    <= pk + 3'd1;
              state <= B_PMUL;
            end
          end
        end
        B_AMUL: state <= B_ASTORE;
        B_ASTORE: begin
          if (ck == 2'd1) begin
            comp[1] <= {mul_p[31:0], 8'd0};
          end else begin
            comp[ck] <= 40'(mul_p[30:0]);
          end
          if (ck == 2'd2) begin
            state <= B_NORM;
          end else begin
            ck    <= ck + 2'd1;
            state <= B_AMUL;
          end
        end
        B_NORM: begin
          // Bring the largest magnitude into [2^29, 2^30), one bit a cycle.
          if (m_max == '0) begin
            nm[0] <= '0;
            nm[1] <= 15'(hvn_pkg::NORM_ONE);
            nm[2] <= '0;
            state <= B_FIN;
          end else if (m_max[39:30] != '0) begin
            for (int i = 0; i < 3; i++) comp[i] <= comp[i] >> 1;
          end else if (!m_max[29]) begin
            for (int i = 0; i < 3; i++) comp[i] <= comp[i] << 1;
          end else begin
            ck    <= '0;
            sum   <= '0;
            state <= B_SQMUL;
          end
        end
        B_SQMUL: state <= B_SQACC;
        B_SQACC: begin
          if (ck == 2'd2) begin
            sq_v   <= 63'(sum + mul_p[59:0]);
            sq_res <= '0;
            sq_bit <= 63'(1) << 62;
            sq_cnt <= 5'd31;
            state  <= B_SQRT;
          end else begin
            sum   <= sum + 62'(mul_p[59:0]);
            ck    <= ck + 2'd1;
            state <= B_SQMUL;
          end
        end
        B_SQRT: begin
          if (sq_v >= sq_trial) begin
            sq_v   <= sq_v - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_cnt == '0) begin
            ck    <= '0;
            state <= B_SDIV;
          end else begin
            sq_cnt <= sq_cnt - 5'd1;
          end
        end
        B_SDIV: state <= B_SWAIT;
        B_SWAIT: begin
          if (div_done) begin
            nm[ck] <= (div_quo > hvn_pkg::DIV_NW'(hvn_pkg::NORM_ONE)) ?
                      15'(hvn_pkg::NORM_ONE) : div_quo[14:0];
            if (ck == 2'd2) begin
              state <= B_FIN;
            end else begin
              ck    <= ck + 2'd1;
              state <= B_SDIV;
            end
          end
        end
        B_FIN: begin
          pos_x      <= pq[0];
          pos_z      <= pq[3];
          pos_height <= h_c;
          normal_x   <= dhx_pos ? (16'd0 - {1'b0, nm[0]}) : {1'b0, nm[0]};
          normal_y   <= nm[1];
          normal_z   <= dhz_pos ? (16'd0 - {1'b0, nm[2]}) : {1'b0, nm[2]};
          tex_u      <= job_q.col[9:0];
          tex_v      <= job_q.row[9:0];
          frame_last <= job_q.last;
          out_valid  <= 1'b1;
          state      <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hdl/heightmap_vertex_normal_gen_unit.sv */
// ----------------------------------------------------------------------------
// Height map vertex generator
// Turns a raster stream of height samples into vertices with unit normals.
// ----------------------------------------------------------------------------
// Past the first row, the front end reads four stored samples per sample taken
// and pushes up to three vertex jobs. Back end: six 46-step divisions for the
// position, then, unless the normal is straight up, the 32-step root and three
// more divisions.
// Synchronous reset clears counters, holds, queue and handshakes and restores
// 256 x 256 with extents of 64.0; the store is not cleared.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_gen_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [hvn_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      height_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     pos_x,
  output logic [14:0]                     pos_height,
  output logic [15:0]                     pos_z,
  output logic signed [15:0]              normal_x,
  output logic [14:0]                     normal_y,
  output logic signed [15:0]              normal_z,
  output logic [9:0]                      tex_u,
  output logic [9:0]                      tex_v,
  output logic                            frame_last
);

  // Configuration registers: write only while the block is idle; not enforced.
  logic [hvn_pkg::DIM_W-1:0]  grid_width, grid_height;
  logic [hvn_pkg::SIZE_W-1:0] size_x, size_z;
  logic [hvn_pkg::DIM_W-1:0]  w_eff, h_eff;

  // Request queue between the two halves.
  logic          job_push, job_full, job_pop, job_empty;
  hvn_pkg::job_t job_in, job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 11'd256;
      grid_height <= 11'd256;
      size_x      <= 16'd1024;
      size_z      <= 16'd1024;
    end else if (cfg_we) begin
      unique case (hvn_pkg::cfg_index_t'(cfg_index))
        hvn_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[hvn_pkg::DIM_W-1:0];
        hvn_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[hvn_pkg::DIM_W-1:0];
        hvn_pkg::CFG_SIZE_X:      size_x      <= cfg_data;
        hvn_pkg::CFG_SIZE_Z:      size_z      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid dimensions below two act as two, above the maxima as the maxima.
  always_comb begin
    if (grid_width < 11'd2) begin
      w_eff = 11'd2;
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      w_eff = hvn_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height < 11'd2) begin
      h_eff = 11'd2;
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      h_eff = hvn_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  // Every register write restarts the frame in the front end.
  hvn_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_clear    (cfg_we),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .height_sample(height_sample),
    .job_valid    (job_push),
    .job_full     (job_full),
    .job_data     (job_in)
  );

  hvn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_data(job_in),
    .full     (job_full),
    .pop      (job_pop),
    .pop_data (job_out),
    .empty    (job_empty)
  );

  // The back end holds its result in output registers while the front end
  // keeps taking samples and pushing jobs until the queue is full.
  hvn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .size_x    (size_x),
    .size_z    (size_z),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_height(pos_height),
    .pos_z     (pos_z),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .tex_u     (tex_u),
    .tex_v     (tex_v),
    .frame_last(frame_last)
  );

endmodule

/* hdl/hvn_checker.sv */
// ----------------------------------------------------------------------------
// Height map vertex port checker
// Watches the result port of the top level over time.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_gen_unit_defines.svh"

module hvn_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        pos_x,
  input logic [14:0]        pos_height,
  input logic signed [15:0] normal_x,
  input logic [14:0]        normal_y,
  input logic [9:0]         tex_u
);

  `HVN_CHECK_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid after reset")
  `HVN_CHECK(a_hold, out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(normal_x) && $stable(tex_u), "stalled result changed")
  `HVN_CHECK(a_ny_range, out_valid |-> normal_y <= 15'd16384, "normal y above one")
  `HVN_CHECK(a_nx_range, out_valid |-> (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384), "normal x out of range")
  `HVN_CHECK(a_height_range, out_valid |-> pos_height <= 15'd20480, "height above five")

endmodule

bind heightmap_vertex_normal_gen_unit hvn_checker u_hvn_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pos_x     (pos_x),
  .pos_height(pos_height),
  .normal_x  (normal_x),
  .normal_y  (normal_y),
  .tex_u     (tex_u)
);
